// File: hdl/mdf_pkg.sv
`timescale 1ns / 1ps

package mdf_pkg;

    localparam int unsigned MAX_BODY = 64;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_START_PATTERN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BODY_LEN  = 2'd1;

    localparam logic [31:0] START_PATTERN_RST = 32'h1857_FC0A;
    localparam logic [6:0]  MAX_BODY_LEN_RST  = 7'd64;

    localparam logic [31:0] CRC32_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC32_INIT = 32'hFFFF_FFFF;

    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_C = 8'h43;
    localparam logic [7:0] CHAR_K = 8'h4B;

    typedef enum logic [2:0] {
        ST_IN_PROGRESS = 3'd0,
        ST_GOOD_DATA   = 3'd1,
        ST_GOOD_ACK    = 3'd2,
        ST_LEN_ERR     = 3'd3,
        ST_SUM_ERR     = 3'd4,
        ST_CRC_ERR     = 3'd5
    } status_t;

    // One received byte held in the input register
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        has_data;
        logic        last;
        status_t     status;
        logic [31:0] hdr_index;
        logic        ack_wanted;
        logic        index_gap;
    } result_t;

    // Reflected CRC-32, one byte, LSB first
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] r;
        r = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ CRC32_POLY) : (r >> 1);
        end
        return r;
    endfunction

    function automatic logic [7:0] ack_char(input logic [1:0] pos);
        logic [7:0] c;
        case (pos)
            2'd0:    c = CHAR_A;
            2'd1:    c = CHAR_C;
            default: c = CHAR_K;
        endcase
        return c;
    endfunction

endpackage

// File: hdl/mdf_in_stage.sv
`timescale 1ns / 1ps

module mdf_in_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_tdata,
    output mdf_pkg::item_t  item,
    input  logic            item_take
);

    logic       valid_reg;
    logic [7:0] data_reg;

    // Accept whenever the held byte is empty or leaves this cycle
    assign s_tready = !valid_reg || item_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            valid_reg <= 1'b1;
        end else if (item_take) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            data_reg <= s_tdata;
        end
    end

    assign item.valid = valid_reg;
    assign item.data  = data_reg;

endmodule

// File: hdl/mdf_core.sv
`timescale 1ns / 1ps

module mdf_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [mdf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mdf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  mdf_pkg::item_t                     item,
    output logic                               item_take,
    output logic                               res_valid,
    input  logic                               res_ready,
    output mdf_pkg::result_t                   res
);

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_HEAD = 2'd1,
        PH_BODY = 2'd2
    } phase_t;

    // Header byte positions
    localparam logic [3:0] HDR_LEN      = 4'd4;
    localparam logic [3:0] HDR_ACK      = 4'd12;
    localparam logic [3:0] HDR_SUM_LO   = 4'd14;
    localparam logic [3:0] HDR_LAST     = 4'd15;
    localparam logic [7:0] BODY_LIMIT   = 8'(mdf_pkg::MAX_BODY);

    logic [31:0] start_pattern_reg;
    logic [6:0]  max_len_reg;

    phase_t      phase_reg, phase_next;
    logic [31:0] pattern_reg, pattern_next;
    logic [3:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [31:0] index_reg, index_next;
    logic [6:0]  length_reg, length_next;
    logic        too_long_reg, too_long_next;
    logic [31:0] exp_crc_reg, exp_crc_next;
    logic        ack_flag_reg, ack_flag_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  rx_sum_lo_reg, rx_sum_lo_next;
    logic [6:0]  body_cnt_reg, body_cnt_next;
    logic [31:0] crc_reg, crc_next;
    logic        ack_match_reg, ack_match_next;
    logic [31:0] last_good_reg, last_good_next;

    logic              out_valid_reg;
    mdf_pkg::result_t  out_reg;

    logic              proc;
    logic              emit;
    mdf_pkg::result_t  emit_res;
    logic              fin_en;
    logic [31:0]       fin_crc;
    logic              fin_match;
    logic [7:0]        b;
    logic [31:0]       pattern_new;
    logic [31:0]       crc_new;
    logic [7:0]        limit;
    logic [15:0]       rx_sum;

    assign proc      = item.valid && (!out_valid_reg || res_ready);
    assign item_take = proc;
    assign b         = item.data;

    assign limit  = ({1'b0, max_len_reg} < BODY_LIMIT) ? {1'b0, max_len_reg} : BODY_LIMIT;
    assign rx_sum = {b, rx_sum_lo_reg};
    assign pattern_new = {b, pattern_reg[31:8]};
    assign crc_new = mdf_pkg::crc32_byte(crc_reg, b);

    always_comb begin
        phase_next     = phase_reg;
        pattern_next   = pattern_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        index_next     = index_reg;
        length_next    = length_reg;
        too_long_next  = too_long_reg;
        exp_crc_next   = exp_crc_reg;
        ack_flag_next  = ack_flag_reg;
        sum_next       = sum_reg;
        rx_sum_lo_next = rx_sum_lo_reg;
        body_cnt_next  = body_cnt_reg;
        crc_next       = crc_reg;
        ack_match_next = ack_match_reg;
        last_good_next = last_good_reg;

        emit                   = 1'b0;
        fin_en                 = 1'b0;
        fin_crc                = crc_reg;
        fin_match              = ack_match_reg;
        emit_res.data_byte     = 8'd0;
        emit_res.has_data      = 1'b0;
        emit_res.last          = 1'b0;
        emit_res.status        = mdf_pkg::ST_IN_PROGRESS;
        emit_res.hdr_index     = index_reg;
        emit_res.ack_wanted    = ack_flag_reg;
        emit_res.index_gap     = 1'b0;

        if (proc) begin
            case (phase_reg)
                PH_HEAD: begin
                    if (hdr_cnt_reg < HDR_SUM_LO) begin
                        sum_next = sum_reg + {8'd0, b};
                    end
                    if (hdr_cnt_reg != HDR_LAST) begin
                        hdr_cnt_next = hdr_cnt_reg + 4'd1;
                    end
                    case (hdr_cnt_reg) inside
                        [4'd0:4'd3]: begin
                            index_next[{hdr_cnt_reg[1:0], 3'b000} +: 8] = b;
                        end
                        HDR_LEN: begin
                            length_next   = b[6:0];
                            too_long_next = b[7];
                        end
                        [4'd5:4'd7]: begin
                            if (b != 8'd0) begin
                                too_long_next = 1'b1;
                            end
                        end
                        [4'd8:4'd11]: begin
                            exp_crc_next[{hdr_cnt_reg[1:0], 3'b000} +: 8] = b;
                        end
                        HDR_ACK: begin
                            ack_flag_next = (b != 8'd0);
                        end
                        HDR_SUM_LO: begin
                            rx_sum_lo_next = b;
                        end
                        HDR_LAST: begin
                            if (too_long_reg || ({1'b0, length_reg} > limit)) begin
                                emit            = 1'b1;
                                emit_res.last   = 1'b1;
                                emit_res.status = mdf_pkg::ST_LEN_ERR;
                                phase_next      = PH_HUNT;
                            end else if (sum_reg != rx_sum) begin
                                emit            = 1'b1;
                                emit_res.last   = 1'b1;
                                emit_res.status = mdf_pkg::ST_SUM_ERR;
                                phase_next      = PH_HUNT;
                            end else if (length_reg == 7'd0) begin
                                fin_en = 1'b1;
                            end else begin
                                phase_next = PH_BODY;
                            end
                        end
                        default: ;
                    endcase
                end
                PH_BODY: begin
                    crc_next = crc_new;
                    if (body_cnt_reg < 7'd3 && b != mdf_pkg::ack_char(body_cnt_reg[1:0])) begin
                        ack_match_next = 1'b0;
                    end
                    body_cnt_next      = body_cnt_reg + 7'd1;
                    emit               = 1'b1;
                    emit_res.data_byte = b;
                    emit_res.has_data  = 1'b1;
                    if (body_cnt_next >= length_reg) begin
                        fin_en    = 1'b1;
                        fin_crc   = crc_new;
                        fin_match = ack_match_next;
                    end
                end
                default: begin
                    phase_next   = PH_HUNT;
                    pattern_next = pattern_new;
                    if (pattern_new == start_pattern_reg) begin
                        phase_next     = PH_HEAD;
                        hdr_cnt_next   = 4'd0;
                        sum_next       = 16'(pattern_new[7:0]) + 16'(pattern_new[15:8])
                                       + 16'(pattern_new[23:16]) + 16'(pattern_new[31:24]);
                        too_long_next  = 1'b0;
                        body_cnt_next  = 7'd0;
                        crc_next       = mdf_pkg::CRC32_INIT;
                        ack_match_next = 1'b1;
                    end
                end
            endcase

            // Close the message: check CRC, spot the ACK text, track index gaps
            if (fin_en) begin
                emit          = 1'b1;
                emit_res.last = 1'b1;
                if (~fin_crc != exp_crc_reg) begin
                    emit_res.status = mdf_pkg::ST_CRC_ERR;
                end else if (length_reg == 7'd3 && fin_match) begin
                    emit_res.status = mdf_pkg::ST_GOOD_ACK;
                end else begin
                    emit_res.status    = mdf_pkg::ST_GOOD_DATA;
                    emit_res.index_gap = (index_reg != last_good_reg + 32'd1);
                    last_good_next     = index_reg;
                end
                phase_next   = PH_HUNT;
                pattern_next = 32'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_pattern_reg <= mdf_pkg::START_PATTERN_RST;
            max_len_reg       <= mdf_pkg::MAX_BODY_LEN_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                mdf_pkg::CFG_START_PATTERN: start_pattern_reg <= cfg_wdata;
                mdf_pkg::CFG_MAX_BODY_LEN:  max_len_reg       <= cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HUNT;
            pattern_reg   <= 32'd0;
            hdr_cnt_reg   <= 4'd0;
            index_reg     <= 32'd0;
            length_reg    <= 7'd0;
            too_long_reg  <= 1'b0;
            exp_crc_reg   <= 32'd0;
            ack_flag_reg  <= 1'b0;
            sum_reg       <= 16'd0;
            rx_sum_lo_reg <= 8'd0;
            body_cnt_reg  <= 7'd0;
            crc_reg       <= mdf_pkg::CRC32_INIT;
            ack_match_reg <= 1'b1;
            last_good_reg <= 32'd0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            pattern_reg   <= pattern_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            index_reg     <= index_next;
            length_reg    <= length_next;
            too_long_reg  <= too_long_next;
            exp_crc_reg   <= exp_crc_next;
            ack_flag_reg  <= ack_flag_next;
            sum_reg       <= sum_next;
            rx_sum_lo_reg <= rx_sum_lo_next;
            body_cnt_reg  <= body_cnt_next;
            crc_reg       <= crc_next;
            ack_match_reg <= ack_match_next;
            last_good_reg <= last_good_next;
            if (proc) begin
                out_valid_reg <= emit;
            end else if (res_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (proc && emit) begin
            out_reg <= emit_res;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

// File: hdl/message_deframer_crc_check_unit.sv
`timescale 1ns / 1ps

// Channel  | Ports                       | Contents
// ---------+-----------------------------+-----------------------------------------
// input    | s_tvalid s_tready s_tdata   | one received byte
// result   | m_tvalid m_tready m_tdata   | body byte, index, ack flag, gap flag
//          | m_tlast m_tuser             | end of message / header reject, status
// config   | cfg_wr_en cfg_index cfg_wdata | 0 start pattern, 1 max body length
//
// One byte per clock sustained while m_tready is high; the result of a byte passes through the
// input register, then the deframer update into the result register.
// Reset restores the register defaults and starts hunting for the start pattern.
// With m_tready low the result holds; one more byte waits in the input register
// before s_tready drops.
module message_deframer_crc_check_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [7:0] rx_byte
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [7:0] data_byte, [39:8] message index, [40] ack_wanted, [41] index_gap, rest zero
    output logic [47:0]                        m_tdata,
    output logic                               m_tlast,
    output logic [3:0]                         m_tuser,   // [0] has_data, [3:1] status
    input  logic                               cfg_wr_en,
    input  logic [mdf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mdf_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    mdf_pkg::item_t    item;
    logic              item_take;
    mdf_pkg::result_t  res;

    mdf_in_stage u_in_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .item      (item),
        .item_take (item_take)
    );

    mdf_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .item      (item),
        .item_take (item_take),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {6'd0, res.index_gap, res.ack_wanted, res.hdr_index, res.data_byte};
    assign m_tlast = res.last;
    assign m_tuser = {res.status, res.has_data};

endmodule
